// ===== rtl/crc_checked_packet_deframer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet deframer
// Clocked implication checks with reset masking via disable iff.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define CRC_CHECKED_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication: whenever cond holds, expr holds.
`define CCPD_ASSERT_SAME(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication: whenever cond holds, expr holds in the next cycle.
`define CCPD_ASSERT_NEXT(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/ccpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpd_pkg
// Types, constants and the CRC-16 byte update shared by the deframer.
// ----------------------------------------------------------------------------
package ccpd_pkg;

  localparam logic [7:0]  START_BYTE  = 8'h6E;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'h0000;
  localparam logic [15:0] CRC_MSB     = 16'h8000;

  localparam logic [7:0]  FN_STATUS   = 8'h06;
  localparam logic [7:0]  FN_FFC_DONE = 8'h0C;
  localparam logic [7:0]  FN_TEMP     = 8'h20;
  localparam logic [7:0]  FN_PAN_TILT = 8'h70;

  localparam int PAYLOAD_HEAD_DEPTH = 4;
  localparam int HEAD_IDX_W         = $clog2(PAYLOAD_HEAD_DEPTH);
  localparam int HEAD_CNT_W         = HEAD_IDX_W + 1;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_STATUS,
    PH_RSVD,
    PH_FUNC,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_HCRC_HI,
    PH_HCRC_LO,
    PH_PAYLOAD,
    PH_TCRC_HI,
    PH_TCRC_LO
  } phase_t;

  typedef enum logic [2:0] {
    KIND_OTHER,
    KIND_CAM_STATUS,
    KIND_FFC_DONE,
    KIND_TEMP,
    KIND_PAN_TILT
  } kind_t;

  typedef logic [PAYLOAD_HEAD_DEPTH-1:0][7:0] payload_head_t;

  typedef struct packed {
    logic [7:0]         pan_hi;
    logic [7:0]         pan_lo;
    logic signed [15:0] tilt_position;
    logic signed [15:0] fpa_temperature;
    logic [7:0]         camera_status;
    logic [15:0]        payload_length;
    logic [7:0]         function_code;
    logic [7:0]         status_byte;
  } record_t;

  typedef struct packed {
    logic [7:0]  frame_status;
    logic [7:0]  frame_function;
    logic [15:0] frame_length;
  } header_t;

  // MSB-first CRC-16 update over one byte, no reflection
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/ccpd_record_decode.sv =====
// ----------------------------------------------------------------------------
// ccpd_record_decode
// Picks the record kind from function code and length and extracts fields.
// ----------------------------------------------------------------------------
module ccpd_record_decode (
  input  ccpd_pkg::header_t       hdr,
  input  ccpd_pkg::payload_head_t payload_head,
  output ccpd_pkg::record_t       rec,
  output ccpd_pkg::kind_t         kind
);
  import ccpd_pkg::*;

  logic [15:0] be01;
  logic [15:0] be23;

  assign be01 = {payload_head[0], payload_head[1]};
  assign be23 = {payload_head[2], payload_head[3]};

  always_comb begin
    rec                = '0;
    rec.status_byte    = hdr.frame_status;
    rec.function_code  = hdr.frame_function;
    rec.payload_length = hdr.frame_length;
    kind               = KIND_OTHER;
    // first match wins
    if (hdr.frame_function == FN_STATUS && hdr.frame_length >= 16'd1) begin
      kind              = KIND_CAM_STATUS;
      rec.camera_status = payload_head[0];
    end else if (hdr.frame_function == FN_FFC_DONE) begin
      kind = KIND_FFC_DONE;
    end else if (hdr.frame_function == FN_TEMP && hdr.frame_length >= 16'd2) begin
      kind                = KIND_TEMP;
      rec.fpa_temperature = be01;
    end else if (hdr.frame_function == FN_PAN_TILT && hdr.frame_length >= 16'd4) begin
      kind              = KIND_PAN_TILT;
      rec.tilt_position = be01;
      rec.pan_hi        = be23[15:8];
      rec.pan_lo        = be23[7:0];
    end
  end

endmodule

// ===== rtl/crc_checked_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// crc_checked_packet_deframer_unit
// Byte-stream deframer with header and trailing CRC-16 checks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per word in tdata[7:0]. The block hunts
//   for the start byte, walks the header, payload and trailing CRC, and on the
//   last byte of a frame whose two CRCs both match emits one decoded record
//   on m_axis (tdata holds the record fields, tuser the record kind).
//   Frames with a bad CRC are dropped without any output.
// Throughput and timing:
//   One byte per cycle outside the stall below. The record appears on m_axis in
//   the cycle after the final CRC byte is taken; the byte path is a single
//   registered pass through the CRC-16 byte update and the frame state machine.
// Reset:
//   rst (synchronous) returns the block to hunting and empties the output.
// Stall:
//   While a record waits in the output register, bytes other than the final
//   CRC byte are still taken; the final byte of the next frame is held off
//   until the waiting record leaves.
// ----------------------------------------------------------------------------
module crc_checked_packet_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // [7:0] status_byte, [15:8] function_code,
                                     // [31:16] payload_length, [39:32] camera_status,
                                     // [55:40] fpa_temperature, [71:56] tilt_position,
                                     // [87:72] pan_position
  output logic [2:0]  m_axis_tuser   // [2:0] kind
);
  import ccpd_pkg::*;

  `include "crc_checked_packet_deframer_unit_assert.svh"

  phase_t                phase, phase_next;
  logic [15:0]           bytes_left, bytes_left_next;
  logic [15:0]           running_crc, running_crc_next;
  logic [15:0]           header_crc_calc, header_crc_calc_next;
  logic                  header_crc_ok, header_crc_ok_next;
  logic [7:0]            received_crc_high, received_crc_high_next;
  header_t               hdr, hdr_next;
  payload_head_t         payload_head;
  logic [HEAD_CNT_W-1:0] head_cnt, head_cnt_next;
  logic                  head_wr;

  logic        in_acc;
  logic [7:0]  b;
  logic [15:0] crc_base;
  logic [15:0] crc_upd;
  logic        frame_good;
  logic        emit;

  record_t rec;
  kind_t   rec_kind;

  assign b             = s_axis_tdata;
  assign s_axis_tready = (phase != PH_TCRC_LO) || !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign crc_base   = (phase == PH_HUNT) ? CRC_INIT : running_crc;
  assign crc_upd    = crc16_byte(crc_base, b);
  assign frame_good = header_crc_ok && ({received_crc_high, b} == running_crc);
  assign emit       = in_acc && (phase == PH_TCRC_LO) && frame_good;

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT:    if (b == START_BYTE) phase_next = PH_STATUS;
      PH_STATUS:  phase_next = PH_RSVD;
      PH_RSVD:    phase_next = PH_FUNC;
      PH_FUNC:    phase_next = PH_LEN_HI;
      PH_LEN_HI:  phase_next = PH_LEN_LO;
      PH_LEN_LO:  phase_next = PH_HCRC_HI;
      PH_HCRC_HI: phase_next = PH_HCRC_LO;
      PH_HCRC_LO: phase_next = (hdr.frame_length == 16'd0) ? PH_TCRC_HI : PH_PAYLOAD;
      PH_PAYLOAD: if (bytes_left == 16'd1) phase_next = PH_TCRC_HI;
      PH_TCRC_HI: phase_next = PH_TCRC_LO;
      PH_TCRC_LO: phase_next = PH_HUNT;
      default:    phase_next = PH_HUNT;
    endcase
  end

  // datapath updates per phase
  always_comb begin
    bytes_left_next        = bytes_left;
    running_crc_next       = running_crc;
    header_crc_calc_next   = header_crc_calc;
    header_crc_ok_next     = header_crc_ok;
    received_crc_high_next = received_crc_high;
    hdr_next               = hdr;
    head_cnt_next          = head_cnt;
    head_wr                = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          running_crc_next   = crc_upd;
          header_crc_ok_next = 1'b0;
        end
      end
      PH_STATUS: begin
        running_crc_next      = crc_upd;
        hdr_next.frame_status = b;
      end
      PH_RSVD: running_crc_next = crc_upd;
      PH_FUNC: begin
        running_crc_next        = crc_upd;
        hdr_next.frame_function = b;
      end
      PH_LEN_HI: begin
        running_crc_next      = crc_upd;
        hdr_next.frame_length = {b, 8'h00};
      end
      PH_LEN_LO: begin
        running_crc_next      = crc_upd;
        hdr_next.frame_length = {hdr.frame_length[15:8], b};
        header_crc_calc_next  = crc_upd;
      end
      PH_HCRC_HI: begin
        running_crc_next       = crc_upd;
        received_crc_high_next = b;
      end
      PH_HCRC_LO: begin
        running_crc_next   = crc_upd;
        header_crc_ok_next = ({received_crc_high, b} == header_crc_calc);
        bytes_left_next    = hdr.frame_length;
        head_cnt_next      = '0;
      end
      PH_PAYLOAD: begin
        running_crc_next = crc_upd;
        bytes_left_next  = bytes_left - 16'd1;
        // keep only the head of the payload
        if (head_cnt < HEAD_CNT_W'(PAYLOAD_HEAD_DEPTH)) begin
          head_wr       = 1'b1;
          head_cnt_next = head_cnt + HEAD_CNT_W'(1);
        end
      end
      PH_TCRC_HI: received_crc_high_next = b;
      PH_TCRC_LO: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      bytes_left    <= '0;
      running_crc   <= CRC_INIT;
      header_crc_ok <= 1'b0;
      head_cnt      <= '0;
    end else if (in_acc) begin
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      running_crc   <= running_crc_next;
      header_crc_ok <= header_crc_ok_next;
      head_cnt      <= head_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      header_crc_calc   <= header_crc_calc_next;
      received_crc_high <= received_crc_high_next;
      hdr               <= hdr_next;
      if (head_wr) begin
        payload_head[head_cnt[HEAD_IDX_W-1:0]] <= b;
      end
    end
  end

  ccpd_record_decode u_decode (
    .hdr          (hdr),
    .payload_head (payload_head),
    .rec          (rec),
    .kind         (rec_kind)
  );

  // output register: load on a good final byte, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= rec;
      m_axis_tuser <= rec_kind;
    end
  end

  `CCPD_ASSERT_NEXT(a_no_spurious_out, clk, rst,
    !emit && !m_axis_tvalid, !m_axis_tvalid)
  `CCPD_ASSERT_SAME(a_no_overwrite, clk, rst,
    m_axis_tvalid && !m_axis_tready && phase == PH_TCRC_LO, !s_axis_tready)
  `CCPD_ASSERT_SAME(a_pan_tilt_len, clk, rst,
    m_axis_tvalid && m_axis_tuser == KIND_PAN_TILT, m_axis_tdata[31:16] >= 16'd4)
  `CCPD_ASSERT_SAME(a_head_cnt_range, clk, rst,
    1'b1, head_cnt <= HEAD_CNT_W'(PAYLOAD_HEAD_DEPTH))
  `CCPD_ASSERT_SAME(a_payload_nonzero, clk, rst,
    phase == PH_PAYLOAD, bytes_left != 16'd0)

endmodule
